[design/obstacle_inflation_filter_core_macros.svh]
// ----------------------------------------------------------------------------
// Obstacle inflation filter assertion macros
// Concurrent assertion helpers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_INFLATION_FILTER_CORE_MACROS_SVH
`define OBSTACLE_INFLATION_FILTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OIF_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("oif assertion failed");

// next-cycle implication
`define OIF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("oif assertion failed");

`else

`define OIF_ASSERT_IMPLY(label, clk, rst, pre, post)
`define OIF_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

[design/oif_pkg.sv]
// ----------------------------------------------------------------------------
// Obstacle inflation filter package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package oif_pkg;

   localparam int PIXEL_W      = 8;
   localparam int OUT_POS_W    = 10;
   localparam int CSR_DATA_W   = 11;
   localparam int CSR_INDEX_W  = 3;
   localparam int RADIUS_CFG_W = 5;

   localparam int BURST_CAP = 32;
   localparam int BURST_W   = 6;

   localparam int ROWS_RESET      = 1024;
   localparam int COLS_RESET      = 1024;
   localparam int RADIUS_RESET    = 25;
   localparam int THRESHOLD_RESET = 125;

   typedef logic [PIXEL_W-1:0]     pixel_type;
   typedef logic [OUT_POS_W-1:0]   out_pos_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   typedef enum logic {
      FUNC_PIXEL = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_ROWS         = 3'd0,
      CSR_IMAGE_COLS         = 3'd1,
      CSR_INFLATE_RADIUS     = 3'd2,
      CSR_OBSTACLE_THRESHOLD = 3'd3
   } csr_reg_type;

endpackage

[design/oif_if.sv]
// ----------------------------------------------------------------------------
// Obstacle inflation filter channel interfaces
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface oif_req_if;
   import oif_pkg::*;

   logic      valid;
   logic      ready;
   func_type  func;
   pixel_type pixel_in;

   modport source (output valid, output func, output pixel_in, input ready);
   modport sink (input valid, input func, input pixel_in, output ready);
endinterface

interface oif_rsp_if;
   import oif_pkg::*;

   logic        valid;
   logic        ready;
   pixel_type   pixel_out;
   out_pos_type out_row;
   out_pos_type out_col;
   logic        run_last;
   logic        image_last;

   modport source (
      output valid, output pixel_out, output out_row, output out_col,
      output run_last, output image_last, input ready
   );
   modport sink (
      input valid, input pixel_out, input out_row, input out_col,
      input run_last, input image_last, output ready
   );
endinterface

interface oif_csr_if;
   import oif_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[design/obstacle_inflation_filter_core.sv]
// ----------------------------------------------------------------------------
// Obstacle inflation filter core
// Streaming square-window obstacle dilation over a raster grey map. A
// sequencer scans the column obstacle record memory one column per cycle
// through a single compare unit for each output pixel.
// Each output is formed by a column scan from the window's left edge to its
//   right edge (2 * radius + 1 columns, clipped at the borders).
// Outputs: up to 32 per pixel request, at most one per drain request.
// Reset: positions return to row 0 column 0, registers to their reset values,
//   then a clearing pass over all MAX_COLS entries empties the column records;
//   the same pass follows each geometry or radius write and each image end.
// ----------------------------------------------------------------------------
`include "obstacle_inflation_filter_core_macros.svh"

module obstacle_inflation_filter_core #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_ROWS   = 1024,
   parameter int MAX_RADIUS = 31
) (
   input  logic      clock,
   input  logic      reset,
   oif_req_if.sink   req_chan,
   oif_rsp_if.source rsp_chan,
   oif_csr_if.sink   csr_chan
);
   import oif_pkg::*;

   localparam int RNW        = $clog2(MAX_ROWS + 1);
   localparam int CNW        = $clog2(MAX_COLS + 1);
   localparam int CW         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RDW        = $clog2(MAX_RADIUS + 1);
   localparam int STORE_ROWS = MAX_RADIUS + 1;
   localparam int SW         = $clog2(STORE_ROWS);
   localparam int MW1        = (RNW > CNW) ? RNW : CNW;
   localparam int PW         = ((MW1 > RDW) ? MW1 : RDW) + 1;

   localparam int ROWS_EFF_RESET = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
   localparam int COLS_EFF_RESET = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;
   localparam int RAD_EFF_RESET  = (RADIUS_RESET > MAX_RADIUS) ? MAX_RADIUS : RADIUS_RESET;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_START,
      S_SCAN,
      S_TAIL
   } state_type;

   // memories
   pixel_type        pix_mem [STORE_ROWS][MAX_COLS];
   logic [RNW:0]     col_mem [MAX_COLS];

   state_type        state_ff, state_in;
   logic             clear_busy_ff, clear_busy_in;
   logic [CW-1:0]    clear_addr_ff, clear_addr_in;
   logic [RNW-1:0]   rows_ff, rows_in;
   logic [CNW-1:0]   cols_ff, cols_in;
   logic [RDW-1:0]   rad_ff, rad_in;
   pixel_type        thr_ff, thr_in;
   logic [RNW-1:0]   in_r_ff, in_r_in;
   logic [CNW-1:0]   in_c_ff, in_c_in;
   logic [SW-1:0]    in_slot_ff, in_slot_in;
   logic [RNW-1:0]   out_r_ff, out_r_in;
   logic [CNW-1:0]   out_c_ff, out_c_in;
   logic [SW-1:0]    out_slot_ff, out_slot_in;
   logic             burst_ff, burst_in;
   logic [BURST_W-1:0] n_ff, n_in;
   logic [CNW-1:0]   scan_c_ff, scan_c_in;
   logic [CNW-1:0]   hi_ff, hi_in;
   logic             near_ff, near_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             pend_valid_ff, pend_valid_in;
   pixel_type        pend_pix_ff, pend_pix_in;
   out_pos_type      pend_row_ff, pend_row_in;
   out_pos_type      pend_col_ff, pend_col_in;
   logic             pend_last_ff, pend_last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pixel_type        rsp_pix_ff, rsp_pix_in;
   out_pos_type      rsp_row_ff, rsp_row_in;
   out_pos_type      rsp_col_ff, rsp_col_in;
   logic             rsp_run_last_ff, rsp_run_last_in;
   logic             rsp_img_last_ff, rsp_img_last_in;

   logic [RNW:0]     col_q_ff;
   pixel_type        pix_q_ff;

   logic             pix_we;
   logic             col_we;
   logic [CW-1:0]    col_waddr;
   logic [RNW:0]     col_wdata;

   logic [PW-1:0]    out_r_w, out_c_w, in_r_w, in_c_w, rad_w;
   logic [PW-1:0]    rows_m1_w, cols_m1_w, tr_sum, tc_sum, tr, tc, lo;
   logic [CNW-1:0]   cols_m1;
   logic             rdy_now, more, can_push, hit, near_now, img_last;
   logic             req_fire, csr_fire, pix_take, restart;
   logic [31:0]      cfg_wide, rows_cfg, cols_cfg, rad_cfg, out_r_32, out_c_32;

   always_comb begin
      out_r_w   = PW'(out_r_ff);
      out_c_w   = PW'(out_c_ff);
      in_r_w    = PW'(in_r_ff);
      in_c_w    = PW'(in_c_ff);
      rad_w     = PW'(rad_ff);
      rows_m1_w = PW'(rows_ff) - PW'(1);
      cols_m1_w = PW'(cols_ff) - PW'(1);
      cols_m1   = cols_ff - CNW'(1);
      tr_sum    = out_r_w + rad_w;
      tc_sum    = out_c_w + rad_w;
      tr        = (tr_sum > rows_m1_w) ? rows_m1_w : tr_sum;
      tc        = (tc_sum > cols_m1_w) ? cols_m1_w : tc_sum;
      lo        = (out_c_w > rad_w) ? (out_c_w - rad_w) : '0;
      rdy_now   = (out_r_w <= rows_m1_w) &&
                  ((in_r_w > tr) || ((in_r_w == tr) && (in_c_w > tc)));
      more      = rdy_now && (burst_ff ? (n_ff < BURST_W'(BURST_CAP)) : (n_ff == '0));
      can_push  = !rsp_valid_ff || rsp_chan.ready;
      hit       = col_q_ff[RNW] && ((PW'(col_q_ff[RNW-1:0]) + rad_w) >= out_r_w);
      near_now  = near_ff || (rd_pend_ff && hit);
      img_last  = (out_r_w == rows_m1_w) && (out_c_w == cols_m1_w);
      out_r_32  = 32'(out_r_ff);
      out_c_32  = 32'(out_c_ff);
      cfg_wide  = 32'(csr_chan.data);
      rows_cfg  = (cfg_wide == 32'd0) ? 32'd1 :
                  (cfg_wide > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : cfg_wide;
      cols_cfg  = (cfg_wide == 32'd0) ? 32'd1 :
                  (cfg_wide > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cfg_wide;
      rad_cfg   = 32'(csr_chan.data[RADIUS_CFG_W-1:0]);
      if (rad_cfg > 32'(MAX_RADIUS)) begin
         rad_cfg = 32'(MAX_RADIUS);
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE) && !clear_busy_ff;
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign pix_take       = (req_chan.func == FUNC_PIXEL) && (in_r_w <= rows_m1_w);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pixel_out  = rsp_pix_ff;
   assign rsp_chan.out_row    = rsp_row_ff;
   assign rsp_chan.out_col    = rsp_col_ff;
   assign rsp_chan.run_last   = rsp_run_last_ff;
   assign rsp_chan.image_last = rsp_img_last_ff;

   always_comb begin
      state_in        = state_ff;
      clear_busy_in   = clear_busy_ff;
      clear_addr_in   = clear_addr_ff;
      rows_in         = rows_ff;
      cols_in         = cols_ff;
      rad_in          = rad_ff;
      thr_in          = thr_ff;
      in_r_in         = in_r_ff;
      in_c_in         = in_c_ff;
      in_slot_in      = in_slot_ff;
      out_r_in        = out_r_ff;
      out_c_in        = out_c_ff;
      out_slot_in     = out_slot_ff;
      burst_in        = burst_ff;
      n_in            = n_ff;
      scan_c_in       = scan_c_ff;
      hi_in           = hi_ff;
      near_in         = near_ff;
      rd_pend_in      = (state_ff == S_SCAN);
      pend_valid_in   = pend_valid_ff;
      pend_pix_in     = pend_pix_ff;
      pend_row_in     = pend_row_ff;
      pend_col_in     = pend_col_ff;
      pend_last_in    = pend_last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_pix_in      = rsp_pix_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_run_last_in = rsp_run_last_ff;
      rsp_img_last_in = rsp_img_last_ff;
      pix_we          = 1'b0;
      col_we          = 1'b0;
      col_waddr       = in_c_ff[CW-1:0];
      col_wdata       = {1'b1, in_r_ff};
      restart         = 1'b0;

      // column record clearing pass
      if (clear_busy_ff) begin
         col_we        = 1'b1;
         col_waddr     = clear_addr_ff;
         col_wdata     = '0;
         clear_addr_in = clear_addr_ff + CW'(1);
         if (clear_addr_ff == CW'(MAX_COLS - 1)) begin
            clear_busy_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               burst_in = pix_take;
               n_in     = '0;
               state_in = S_CHECK;
               if (pix_take) begin
                  pix_we = 1'b1;
                  if (req_chan.pixel_in < thr_ff) begin
                     col_we = 1'b1;
                  end
                  if (in_c_ff == cols_m1) begin
                     in_c_in    = '0;
                     in_r_in    = in_r_ff + RNW'(1);
                     in_slot_in = (in_slot_ff == SW'(STORE_ROWS - 1)) ? '0 :
                                  in_slot_ff + SW'(1);
                  end else begin
                     in_c_in = in_c_ff + CNW'(1);
                  end
               end
            end
         end
         S_CHECK: begin
            if (pend_valid_ff) begin
               if (can_push) begin
                  rsp_valid_in    = 1'b1;
                  rsp_pix_in      = pend_pix_ff;
                  rsp_row_in      = pend_row_ff;
                  rsp_col_in      = pend_col_ff;
                  rsp_img_last_in = pend_last_ff;
                  rsp_run_last_in = !more;
                  pend_valid_in   = 1'b0;
                  state_in        = more ? S_START : S_IDLE;
               end
            end else begin
               state_in = more ? S_START : S_IDLE;
            end
         end
         S_START: begin
            scan_c_in = CNW'(lo);
            hi_in     = CNW'(tc);
            near_in   = 1'b0;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            near_in = near_now;
            if (scan_c_ff == hi_ff) begin
               state_in = S_TAIL;
            end else begin
               scan_c_in = scan_c_ff + CNW'(1);
            end
         end
         S_TAIL: begin
            pend_valid_in = 1'b1;
            pend_pix_in   = near_now ? '0 : pix_q_ff;
            pend_row_in   = out_r_32[OUT_POS_W-1:0];
            pend_col_in   = out_c_32[OUT_POS_W-1:0];
            pend_last_in  = img_last;
            n_in          = n_ff + BURST_W'(1);
            state_in      = S_CHECK;
            if (img_last) begin
               restart = 1'b1;
            end else if (out_c_ff == cols_m1) begin
               out_c_in    = '0;
               out_r_in    = out_r_ff + RNW'(1);
               out_slot_in = (out_slot_ff == SW'(STORE_ROWS - 1)) ? '0 :
                             out_slot_ff + SW'(1);
            end else begin
               out_c_in = out_c_ff + CNW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes
      if (csr_fire) begin
         unique case (csr_reg_type'(csr_chan.index))
            CSR_IMAGE_ROWS: begin
               rows_in = RNW'(rows_cfg);
               restart = 1'b1;
            end
            CSR_IMAGE_COLS: begin
               cols_in = CNW'(cols_cfg);
               restart = 1'b1;
            end
            CSR_INFLATE_RADIUS: begin
               rad_in  = RDW'(rad_cfg);
               restart = 1'b1;
            end
            CSR_OBSTACLE_THRESHOLD: begin
               thr_in = csr_chan.data[PIXEL_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (restart) begin
         in_r_in       = '0;
         in_c_in       = '0;
         in_slot_in    = '0;
         out_r_in      = '0;
         out_c_in      = '0;
         out_slot_in   = '0;
         clear_busy_in = 1'b1;
         clear_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         clear_busy_ff   <= 1'b1;
         clear_addr_ff   <= '0;
         rows_ff         <= RNW'(ROWS_EFF_RESET);
         cols_ff         <= CNW'(COLS_EFF_RESET);
         rad_ff          <= RDW'(RAD_EFF_RESET);
         thr_ff          <= PIXEL_W'(THRESHOLD_RESET);
         in_r_ff         <= '0;
         in_c_ff         <= '0;
         in_slot_ff      <= '0;
         out_r_ff        <= '0;
         out_c_ff        <= '0;
         out_slot_ff     <= '0;
         burst_ff        <= 1'b0;
         n_ff            <= '0;
         near_ff         <= 1'b0;
         rd_pend_ff      <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clear_busy_ff   <= clear_busy_in;
         clear_addr_ff   <= clear_addr_in;
         rows_ff         <= rows_in;
         cols_ff         <= cols_in;
         rad_ff          <= rad_in;
         thr_ff          <= thr_in;
         in_r_ff         <= in_r_in;
         in_c_ff         <= in_c_in;
         in_slot_ff      <= in_slot_in;
         out_r_ff        <= out_r_in;
         out_c_ff        <= out_c_in;
         out_slot_ff     <= out_slot_in;
         burst_ff        <= burst_in;
         n_ff            <= n_in;
         near_ff         <= near_in;
         rd_pend_ff      <= rd_pend_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      scan_c_ff       <= scan_c_in;
      hi_ff           <= hi_in;
      pend_pix_ff     <= pend_pix_in;
      pend_row_ff     <= pend_row_in;
      pend_col_ff     <= pend_col_in;
      pend_last_ff    <= pend_last_in;
      rsp_pix_ff      <= rsp_pix_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_img_last_ff <= rsp_img_last_in;
   end

   // pending row ring
   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[in_slot_ff][in_c_ff[CW-1:0]] <= req_chan.pixel_in;
      end
      pix_q_ff <= pix_mem[out_slot_ff][out_c_ff[CW-1:0]];
   end

   // column obstacle records
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      col_q_ff <= col_mem[scan_c_ff[CW-1:0]];
   end

   `OIF_ASSERT_IMPLY(a_clear_blocks_req, clock, reset, clear_busy_ff, !req_chan.ready)
   `OIF_ASSERT_IMPLY(a_image_end_ends_run, clock, reset, rsp_chan.valid && rsp_chan.image_last, rsp_chan.run_last)
   `OIF_ASSERT_IMPLY(a_in_col_range, clock, reset, 1'b1, in_c_ff <= cols_m1)
   `OIF_ASSERT_IMPLY(a_burst_cap, clock, reset, state_ff == S_CHECK, n_ff <= BURST_W'(BURST_CAP))
   `OIF_ASSERT_NEXT(a_scan_ends, clock, reset, state_ff == S_SCAN && scan_c_ff == hi_ff, state_ff == S_TAIL)

endmodule
